// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl top level
// depends on nothing; pulled in by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RCFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcfs assertion failed");

// next-cycle implication, disabled in reset
`define RCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcfs assertion failed");

`endif

// ----- hw/rtl/rcfs_pkg.sv -----
// shared constants for the rotated crop fill scale unit
// no dependencies; used by the cordic, the top level and the testbench
package rcfs_pkg;

    // default configuration of the datapath
    localparam int DEF_SCALE_FRAC_BITS = 16;
    localparam int DEF_CORDIC_STAGES   = 20;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_HEIGHT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_NUM       = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROT_DEN       = 4'd3;

    // status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    // fixed point constants, q30
    localparam logic [31:0] PI_Q30          = 32'd3373259426;
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;
    localparam logic [30:0] ONE_Q30         = 31'd1073741824;

    // arctangent of 2^-i in q30
    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314857, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
        30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

endpackage

// ----- hw/rtl/rcfs_divider.sv -----
// pipelined restoring divider, one quotient bit per register stage
// no package dependency; carries a sideband vector alongside the data
module rcfs_divider #(
    parameter int NUM_W  = 16,
    parameter int DEN_W  = 16,
    parameter int QUO_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quo,
    output logic [NUM_W-1:0]  out_rem,
    output logic [DEN_W-1:0]  out_den,
    output logic [SIDE_W-1:0] out_side
);

    localparam int CW = NUM_W + DEN_W;

    logic              valid_reg [QUO_W];
    logic              valid_next [QUO_W];
    logic [NUM_W-1:0]  rem_reg [QUO_W];
    logic [NUM_W-1:0]  rem_next [QUO_W];
    logic [DEN_W-1:0]  den_reg [QUO_W];
    logic [DEN_W-1:0]  den_next [QUO_W];
    logic [QUO_W-1:0]  quo_reg [QUO_W];
    logic [QUO_W-1:0]  quo_next [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    logic [SIDE_W-1:0] side_next [QUO_W];

    // each stage decides one quotient bit, msb first
    always_comb
    begin
        logic [NUM_W-1:0] r;
        logic [DEN_W-1:0] d;
        logic [QUO_W-1:0] q;
        logic [CW-1:0]    sh;
        logic             take;
        for (int j = 0; j < QUO_W; j++)
        begin
            if (j == 0)
            begin
                valid_next[j] = in_valid;
                r             = in_num;
                d             = in_den;
                q             = '0;
                side_next[j]  = in_side;
            end
            else
            begin
                valid_next[j] = valid_reg[j-1];
                r             = rem_reg[j-1];
                d             = den_reg[j-1];
                q             = quo_reg[j-1];
                side_next[j]  = side_reg[j-1];
            end
            sh   = CW'(d) << (QUO_W - 1 - j);
            take = (CW'(r) >= sh);
            rem_next[j] = take ? (r - sh[NUM_W-1:0]) : r;
            den_next[j] = d;
            q[QUO_W-1-j] = take;
            quo_next[j]  = q;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < QUO_W; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else
        begin
            for (int j = 0; j < QUO_W; j++)
            begin
                valid_reg[j] <= valid_next[j];
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QUO_W; j++)
        begin
            rem_reg[j]  <= rem_next[j];
            den_reg[j]  <= den_next[j];
            quo_reg[j]  <= quo_next[j];
            side_reg[j] <= side_next[j];
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_rem   = rem_reg[QUO_W-1];
    assign out_den   = den_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

// ----- hw/rtl/rcfs_cordic.sv -----
// unrolled rotation-mode cordic giving clamped |cos| and |sin| in q30
// depends on rcfs_pkg for the gain and arctangent table
module rcfs_cordic #(
    parameter int STAGES = 20,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [30:0]       in_angle,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [30:0]       out_cos,
    output logic [30:0]       out_sin,
    output logic [SIDE_W-1:0] out_side
);

    import rcfs_pkg::*;

    logic               valid_reg [STAGES];
    logic               valid_next [STAGES];
    logic signed [32:0] x_reg [STAGES];
    logic signed [32:0] x_next [STAGES];
    logic signed [32:0] y_reg [STAGES];
    logic signed [32:0] y_next [STAGES];
    logic signed [32:0] z_reg [STAGES];
    logic signed [32:0] z_next [STAGES];
    logic [SIDE_W-1:0]  side_reg [STAGES];
    logic [SIDE_W-1:0]  side_next [STAGES];

    logic               fin_valid_reg;
    logic [30:0]        cos_reg;
    logic [30:0]        cos_next;
    logic [30:0]        sin_reg;
    logic [30:0]        sin_next;
    logic [SIDE_W-1:0]  fin_side_reg;

    // one micro-rotation per stage
    always_comb
    begin
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
        logic signed [32:0] at;
        for (int i = 0; i < STAGES; i++)
        begin
            if (i == 0)
            begin
                valid_next[i] = in_valid;
                x             = 33'(CORDIC_GAIN_Q30);
                y             = '0;
                z             = 33'(in_angle);
                side_next[i]  = in_side;
            end
            else
            begin
                valid_next[i] = valid_reg[i-1];
                x             = x_reg[i-1];
                y             = y_reg[i-1];
                z             = z_reg[i-1];
                side_next[i]  = side_reg[i-1];
            end
            at = 33'(ATAN_Q30[i]);
            if (!z[32])
            begin
                x_next[i] = x - (y >>> i);
                y_next[i] = y + (x >>> i);
                z_next[i] = z - at;
            end
            else
            begin
                x_next[i] = x + (y >>> i);
                y_next[i] = y - (x >>> i);
                z_next[i] = z + at;
            end
        end
    end

    // magnitude and clamp to one
    always_comb
    begin
        logic signed [32:0] xa;
        logic signed [32:0] ya;
        xa = x_reg[STAGES-1][32] ? -x_reg[STAGES-1] : x_reg[STAGES-1];
        ya = y_reg[STAGES-1][32] ? -y_reg[STAGES-1] : y_reg[STAGES-1];
        cos_next = (xa > 33'(ONE_Q30)) ? ONE_Q30 : xa[30:0];
        sin_next = (ya > 33'(ONE_Q30)) ? ONE_Q30 : ya[30:0];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
            fin_valid_reg <= valid_reg[STAGES-1];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            x_reg[i]    <= x_next[i];
            y_reg[i]    <= y_next[i];
            z_reg[i]    <= z_next[i];
            side_reg[i] <= side_next[i];
        end
        cos_reg      <= cos_next;
        sin_reg      <= sin_next;
        fin_side_reg <= side_reg[STAGES-1];
    end

    assign out_valid = fin_valid_reg;
    assign out_cos   = cos_reg;
    assign out_sin   = sin_reg;
    assign out_side  = fin_side_reg;

endmodule

// ----- hw/rtl/rotated_crop_fill_scale_unit.sv -----
// top level of the rotated crop fill scale unit
// depends on rcfs_pkg, rcfs_divider, rcfs_cordic and assert_macros.svh

// Fully pipelined: one request per clock, busy is always low, and each result
// is strobed on done once it has passed through the four bit-per-stage
// dividers (angle remainder, angle scaling, side ratio and aspect ratio)
// and the unrolled cordic. The receiver cannot stall; the pipeline never
// holds. Configuration writes are always taken (cfg_ready is high) and
// apply to requests started after the write.
module rotated_crop_fill_scale_unit #(
    parameter int SCALE_FRAC_BITS = rcfs_pkg::DEF_SCALE_FRAC_BITS,
    parameter int CORDIC_STAGES   = rcfs_pkg::DEF_CORDIC_STAGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [15:0]                       layer_width,
    input  logic [15:0]                       layer_height,
    output logic                              done,
    output logic [31:0]                       fill_scale,
    output logic [1:0]                        status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rcfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data
);

    import rcfs_pkg::*;

    `include "assert_macros.svh"

    localparam int QW = 62 - SCALE_FRAC_BITS;

    typedef struct packed {
        logic        err;
        logic        nneg;
        logic [15:0] l;
        logic [15:0] s;
        logic [31:0] a;
        logic [31:0] b;
    } side_a_t;

    typedef struct packed {
        logic        err;
        logic [15:0] l;
        logic [15:0] s;
        logic [31:0] a;
        logic [31:0] b;
    } side_b_t;

    typedef struct packed {
        logic        err;
        logic [30:0] c;
        logic [31:0] a;
        logic [31:0] b;
    } side_d_t;

    typedef struct packed {
        logic err;
        logic sat;
    } side_e_t;

    logic accept;

    // configuration registers
    logic [15:0] cw_reg;
    logic [15:0] ch_reg;
    logic [15:0] num_reg;
    logic [15:0] den_reg;

    // stage 1: captured request
    logic        s1_valid_reg;
    logic [15:0] s1_lw_reg;
    logic [15:0] s1_lh_reg;
    logic [15:0] s1_cw_reg;
    logic [15:0] s1_ch_reg;
    logic [15:0] s1_num_reg;
    logic [15:0] s1_den_reg;

    // stage 2: sign handling, sides, canvas products
    side_a_t     s2_side_next;
    logic [15:0] s2_nabs_next;
    logic [15:0] s2_dabs_next;
    logic        s2_valid_reg;
    side_a_t     s2_side_reg;
    logic [15:0] s2_nabs_reg;
    logic [15:0] s2_dabs_reg;

    // angle remainder divider
    logic                    da_valid;
    logic [15:0]             da_rem;
    logic [15:0]             da_den;
    logic [$bits(side_a_t)-1:0] da_side_raw;
    side_a_t                 da_side;

    // angle reduction stages
    logic [15:0] m1_m_next;
    side_b_t     m1_side_next;
    logic        m1_valid_reg;
    logic [15:0] m1_m_reg;
    logic [15:0] m1_d_reg;
    side_b_t     m1_side_reg;
    logic [14:0] m2_m_next;
    logic        m2_valid_reg;
    logic [14:0] m2_m_reg;
    logic [15:0] m2_d_reg;
    side_b_t     m2_side_reg;
    logic        m3_valid_reg;
    logic [46:0] m3_prod_reg;
    logic [15:0] m3_d_reg;
    side_b_t     m3_side_reg;

    // angle scaling divider
    logic                    db_valid;
    logic [30:0]             db_quo;
    logic [$bits(side_b_t)-1:0] db_side;

    // cordic
    logic                    cd_valid;
    logic [30:0]             cd_cos;
    logic [30:0]             cd_sin;
    logic [$bits(side_b_t)-1:0] cd_side_raw;
    side_b_t                 cd_side;

    // side ratio
    side_d_t     g1_side_next;
    logic        g1_valid_reg;
    logic [46:0] g1_prod_reg;
    logic [15:0] g1_s_reg;
    side_d_t     g1_side_reg;
    logic                    dd_valid;
    logic [46:0]             dd_quo;
    logic [$bits(side_d_t)-1:0] dd_side_raw;
    side_d_t                 dd_side;

    // aspect ratio product and division
    logic        g2_valid_reg;
    logic [46:0] g2_g_reg;
    logic [31:0] g2_p_reg;
    logic [31:0] g2_q_reg;
    logic        g2_err_reg;
    logic        e1_valid_reg;
    logic [63:0] e1_p0_reg;
    logic [46:0] e1_p1_reg;
    logic [31:0] e1_q_reg;
    logic        e1_err_reg;
    logic        e2_valid_reg;
    logic [78:0] e2_n_reg;
    logic [31:0] e2_q_reg;
    logic        e2_err_reg;
    side_e_t     e3_side_next;
    logic        e3_valid_reg;
    logic [78:0] e3_n_reg;
    logic [31:0] e3_q_reg;
    side_e_t     e3_side_reg;
    logic                    de_valid;
    logic [QW-1:0]           de_quo;
    logic [$bits(side_e_t)-1:0] de_side_raw;
    side_e_t                 de_side;

    // output register
    logic        done_reg;
    logic [31:0] fill_scale_reg;
    logic [31:0] fill_scale_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    // configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg  <= 16'd1;
            ch_reg  <= 16'd1;
            num_reg <= 16'd0;
            den_reg <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CANVAS_WIDTH:  cw_reg  <= cfg_data;
                REG_CANVAS_HEIGHT: ch_reg  <= cfg_data;
                REG_ROT_NUM:       num_reg <= cfg_data;
                REG_ROT_DEN:       den_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 2 logic: zero check, sign folding, long and short side, canvas products
    always_comb
    begin
        logic        dneg;
        logic [16:0] d_ext;
        logic [16:0] n_ext;
        logic [16:0] nn;
        dneg  = s1_den_reg[15];
        d_ext = {s1_den_reg[15], s1_den_reg};
        n_ext = {s1_num_reg[15], s1_num_reg};
        nn    = dneg ? (17'd0 - n_ext) : n_ext;
        s2_dabs_next = dneg ? 16'(17'd0 - d_ext) : s1_den_reg;
        s2_nabs_next = nn[16] ? 16'(17'd0 - nn) : nn[15:0];
        s2_side_next.err  = (s1_cw_reg == 16'd0) || (s1_ch_reg == 16'd0) ||
                            (s1_lw_reg == 16'd0) || (s1_lh_reg == 16'd0) ||
                            (s1_den_reg == 16'd0);
        s2_side_next.nneg = nn[16];
        s2_side_next.l    = (s1_lw_reg > s1_lh_reg) ? s1_lw_reg : s1_lh_reg;
        s2_side_next.s    = (s1_lw_reg > s1_lh_reg) ? s1_lh_reg : s1_lw_reg;
        s2_side_next.a    = 32'(s1_cw_reg) * 32'(s1_lh_reg);
        s2_side_next.b    = 32'(s1_lw_reg) * 32'(s1_ch_reg);
    end

    rcfs_divider #(
        .NUM_W  (16),
        .DEN_W  (16),
        .QUO_W  (16),
        .SIDE_W ($bits(side_a_t))
    ) u_div_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_num    (s2_nabs_reg),
        .in_den    (s2_dabs_reg),
        .in_side   (s2_side_reg),
        .out_valid (da_valid),
        .out_quo   (),
        .out_rem   (da_rem),
        .out_den   (da_den),
        .out_side  (da_side_raw)
    );

    assign da_side = side_a_t'(da_side_raw);

    // floor modulo for a negative numerator
    always_comb
    begin
        m1_m_next = (da_side.nneg && (da_rem != 16'd0)) ? (da_den - da_rem) : da_rem;
        m1_side_next.err = da_side.err;
        m1_side_next.l   = da_side.l;
        m1_side_next.s   = da_side.s;
        m1_side_next.a   = da_side.a;
        m1_side_next.b   = da_side.b;
    end

    // fold the angle into the first quadrant
    assign m2_m_next = ({m1_m_reg, 1'b0} > {1'b0, m1_d_reg}) ?
                       15'(m1_d_reg - m1_m_reg) : m1_m_reg[14:0];

    rcfs_divider #(
        .NUM_W  (47),
        .DEN_W  (16),
        .QUO_W  (31),
        .SIDE_W ($bits(side_b_t))
    ) u_div_theta (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m3_valid_reg),
        .in_num    (m3_prod_reg),
        .in_den    (m3_d_reg),
        .in_side   (m3_side_reg),
        .out_valid (db_valid),
        .out_quo   (db_quo),
        .out_rem   (),
        .out_den   (),
        .out_side  (db_side)
    );

    rcfs_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W ($bits(side_b_t))
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (db_valid),
        .in_angle  (db_quo),
        .in_side   (db_side),
        .out_valid (cd_valid),
        .out_cos   (cd_cos),
        .out_sin   (cd_sin),
        .out_side  (cd_side_raw)
    );

    assign cd_side = side_b_t'(cd_side_raw);

    // sideband for the side ratio division
    always_comb
    begin
        g1_side_next.err = cd_side.err;
        g1_side_next.c   = cd_cos;
        g1_side_next.a   = cd_side.a;
        g1_side_next.b   = cd_side.b;
    end

    rcfs_divider #(
        .NUM_W  (47),
        .DEN_W  (16),
        .QUO_W  (47),
        .SIDE_W ($bits(side_d_t))
    ) u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g1_valid_reg),
        .in_num    (g1_prod_reg),
        .in_den    (g1_s_reg),
        .in_side   (g1_side_reg),
        .out_valid (dd_valid),
        .out_quo   (dd_quo),
        .out_rem   (),
        .out_den   (),
        .out_side  (dd_side_raw)
    );

    assign dd_side = side_d_t'(dd_side_raw);

    // overflow test: quotient would not fit in QW bits
    always_comb
    begin
        e3_side_next.err = e2_err_reg;
        e3_side_next.sat = ((e2_n_reg >> QW) >= 79'(e2_q_reg));
    end

    rcfs_divider #(
        .NUM_W  (79),
        .DEN_W  (32),
        .QUO_W  (QW),
        .SIDE_W ($bits(side_e_t))
    ) u_div_aspect (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e3_valid_reg),
        .in_num    (e3_n_reg),
        .in_den    (e3_q_reg),
        .in_side   (e3_side_reg),
        .out_valid (de_valid),
        .out_quo   (de_quo),
        .out_rem   (),
        .out_den   (),
        .out_side  (de_side_raw)
    );

    assign de_side = side_e_t'(de_side_raw);

    // result selection
    always_comb
    begin
        if (de_side.err)
        begin
            fill_scale_next = 32'd0;
            status_next     = STATUS_ZERO;
        end
        else if (de_side.sat)
        begin
            fill_scale_next = 32'hFFFF_FFFF;
            status_next     = STATUS_SAT;
        end
        else
        begin
            fill_scale_next = de_quo[QW-1 -: 32];
            status_next     = STATUS_OK;
        end
    end

    // valid bits of the top level stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
            e3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            m1_valid_reg <= da_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
            g1_valid_reg <= cd_valid;
            g2_valid_reg <= dd_valid;
            e1_valid_reg <= g2_valid_reg;
            e2_valid_reg <= e1_valid_reg;
            e3_valid_reg <= e2_valid_reg;
            done_reg     <= de_valid;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_lw_reg  <= layer_width;
            s1_lh_reg  <= layer_height;
            s1_cw_reg  <= cw_reg;
            s1_ch_reg  <= ch_reg;
            s1_num_reg <= num_reg;
            s1_den_reg <= den_reg;
        end
    end

    // datapath payload registers
    always_ff @(posedge clk)
    begin
        s2_side_reg <= s2_side_next;
        s2_nabs_reg <= s2_nabs_next;
        s2_dabs_reg <= s2_dabs_next;

        m1_m_reg    <= m1_m_next;
        m1_d_reg    <= da_den;
        m1_side_reg <= m1_side_next;
        m2_m_reg    <= m2_m_next;
        m2_d_reg    <= m1_d_reg;
        m2_side_reg <= m1_side_reg;
        m3_prod_reg <= 47'(m2_m_reg) * 47'(PI_Q30);
        m3_d_reg    <= m2_d_reg;
        m3_side_reg <= m2_side_reg;

        g1_prod_reg <= 47'(cd_side.l) * 47'(cd_sin);
        g1_s_reg    <= cd_side.s;
        g1_side_reg <= g1_side_next;

        g2_g_reg   <= 47'(dd_side.c) + dd_quo;
        g2_p_reg   <= (dd_side.a > dd_side.b) ? dd_side.a : dd_side.b;
        g2_q_reg   <= (dd_side.a > dd_side.b) ? dd_side.b : dd_side.a;
        g2_err_reg <= dd_side.err;

        e1_p0_reg  <= 64'(g2_g_reg[31:0]) * 64'(g2_p_reg);
        e1_p1_reg  <= 47'(g2_g_reg[46:32]) * 47'(g2_p_reg);
        e1_q_reg   <= g2_q_reg;
        e1_err_reg <= g2_err_reg;

        e2_n_reg   <= 79'(e1_p0_reg) + {e1_p1_reg, 32'd0};
        e2_q_reg   <= e1_q_reg;
        e2_err_reg <= e1_err_reg;

        e3_n_reg    <= e2_n_reg;
        e3_q_reg    <= e2_q_reg;
        e3_side_reg <= e3_side_next;

        fill_scale_reg <= fill_scale_next;
        status_reg     <= status_next;
    end

    assign done       = done_reg;
    assign fill_scale = fill_scale_reg;
    assign status     = status_reg;

    // checks on the result encoding and the request path
    `RCFS_ASSERT_NOW(a_zero_status_clears_scale, clk, rst_n,
        done && (status == STATUS_ZERO), fill_scale == 32'd0)
    `RCFS_ASSERT_NOW(a_sat_status_full_scale, clk, rst_n,
        done && (status == STATUS_SAT), fill_scale == 32'hFFFF_FFFF)
    `RCFS_ASSERT_NEXT(a_request_enters_pipe, clk, rst_n,
        start && !busy, s1_valid_reg)

endmodule

// ----- sim/rotated_crop_fill_scale_unit_tb.sv -----
// testbench for the rotated crop fill scale unit: directed and random layer sizes
// depends on rcfs_pkg and rotated_crop_fill_scale_unit; checks every strobed result
module rotated_crop_fill_scale_unit_tb;
    import rcfs_pkg::*;

    localparam int FRAC_BITS   = DEF_SCALE_FRAC_BITS;
    localparam int STAGES      = DEF_CORDIC_STAGES;
    localparam int DRAIN_WAIT  = 200;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [31:0] scale;
        logic [1:0]  code;
    } fill_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [15:0]            layer_width;
    logic [15:0]            layer_height;
    logic                   done;
    logic [31:0]            fill_scale;
    logic [1:0]             status;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [15:0]            cfg_data;

    // mirror of the block's registers
    logic [15:0]        canvas_w_q;
    logic [15:0]        canvas_h_q;
    logic signed [15:0] rot_num_q;
    logic signed [15:0] rot_den_q;

    fill_result_t pending_fills[$];
    int           error_count;
    int           requests_sent;
    int           results_checked;
    int           cycle_count;
    bit           no_gaps;

    rotated_crop_fill_scale_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .layer_width  (layer_width),
        .layer_height (layer_height),
        .done         (done),
        .fill_scale   (fill_scale),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // expected fill scale for one layer size under the current registers
    function automatic fill_result_t predict_fill(input logic [15:0] lw, input logic [15:0] lh);
        fill_result_t       r;
        int                 n;
        int                 d;
        int                 m;
        longint             x;
        longint             y;
        longint             z;
        longint             nx;
        longint             c;
        longint             s;
        longint unsigned    long_side;
        longint unsigned    short_side;
        longint unsigned    g;
        longint unsigned    a;
        longint unsigned    b;
        longint unsigned    p;
        longint unsigned    q;
        logic [127:0]       quo;
        r.scale = '0;
        r.code  = STATUS_OK;
        if (canvas_w_q == 0 || canvas_h_q == 0 || lw == 0 || lh == 0 || rot_den_q == 0)
        begin
            r.code = STATUS_ZERO;
            return r;
        end
        // exact reduction of the angle to [0, pi/2]
        n = rot_num_q;
        d = rot_den_q;
        if (d < 0)
        begin
            d = -d;
            n = -n;
        end
        m = n % d;
        if (m < 0)
            m += d;
        if (2 * m > d)
            m = d - m;
        z = longint'((longint'(m) * longint'(PI_Q30)) / longint'(d));
        // rotation mode cordic, floor shifts
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ATAN_Q30[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ATAN_Q30[i]);
            end
            x = nx;
        end
        c = (x < 0) ? -x : x;
        s = (y < 0) ? -y : y;
        if (c > longint'(ONE_Q30))
            c = longint'(ONE_Q30);
        if (s > longint'(ONE_Q30))
            s = longint'(ONE_Q30);
        // side ratio term, then aspect fit
        long_side  = (lw > lh) ? 64'(lw) : 64'(lh);
        short_side = (lw > lh) ? 64'(lh) : 64'(lw);
        g = (long_side * $unsigned(s) + short_side * $unsigned(c)) / short_side;
        a = 64'(canvas_w_q) * 64'(lh);
        b = 64'(lw) * 64'(canvas_h_q);
        p = (a > b) ? a : b;
        q = (a > b) ? b : a;
        quo = ((128'(g) * 128'(p)) / 128'(q)) >> (30 - FRAC_BITS);
        if (quo > 128'hFFFF_FFFF)
        begin
            r.scale = 32'hFFFF_FFFF;
            r.code  = STATUS_SAT;
        end
        else
            r.scale = quo[31:0];
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0h, expected %0h (result %0d)",
                 what, got, want, results_checked);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        fill_result_t want;
        if (rst_n && done)
        begin
            if (pending_fills.size() == 0)
                report("unexpected result", fill_scale, 0);
            else
            begin
                want = pending_fills.pop_front();
                if (fill_scale !== want.scale)
                    report("fill_scale", fill_scale, want.scale);
                if (status !== want.code)
                    report("status", status, want.code);
            end
            results_checked++;
        end
    end

    // idle gap between requests, mostly short
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // send one layer size request
    task automatic send_layer(input logic [15:0] lw, input logic [15:0] lh);
        int gap;
        @(negedge clk);
        start        <= 1'b1;
        layer_width  <= lw;
        layer_height <= lh;
        do
            @(posedge clk);
        while (busy);
        pending_fills.push_back(predict_fill(lw, lh));
        requests_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop requesting and let all results arrive
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_fills.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_CANVAS_WIDTH:  canvas_w_q = value;
            REG_CANVAS_HEIGHT: canvas_h_q = value;
            REG_ROT_NUM:       rot_num_q  = value;
            REG_ROT_DEN:       rot_den_q  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] cw, input logic [15:0] ch,
                             input logic [15:0] num, input logic [15:0] den);
        drain();
        write_reg(REG_CANVAS_WIDTH, cw);
        write_reg(REG_CANVAS_HEIGHT, ch);
        write_reg(REG_ROT_NUM, num);
        write_reg(REG_ROT_DEN, den);
    endtask

    // layer side: mostly full range, some small, a few at the edges
    function automatic logic [15:0] pick_side();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 16'($urandom_range(1, 65535));
        if (r < 85)
            return 16'($urandom_range(1, 64));
        if (r < 92)
            return 16'hFFFF;
        if (r < 97)
            return 16'd1;
        return 16'd0;
    endfunction

    function automatic logic [15:0] pick_den();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 16'($urandom_range(1, 12));
        if (r < 5)
            return 16'(-$urandom_range(1, 12));
        if (r < 6)
            return 16'd0;
        return 16'($urandom);
    endfunction

    // reset values of the registers
    task automatic test_reset_defaults();
        send_layer(16'd1, 16'd1);
        send_layer(16'd640, 16'd480);
        send_layer(16'd480, 16'd640);
    endtask

    // each zero size or zero denominator flags the request
    task automatic test_zero_sizes();
        send_layer(16'd0, 16'd10);
        send_layer(16'd10, 16'd0);
        send_layer(16'd0, 16'd0);
        configure(16'd0, 16'd100, 16'd1, 16'd4);
        send_layer(16'd20, 16'd30);
        configure(16'd100, 16'd0, 16'd1, 16'd4);
        send_layer(16'd20, 16'd30);
        configure(16'd100, 16'd100, 16'd1, 16'd0);
        send_layer(16'd20, 16'd30);
    endtask

    // size extremes, square layer and saturation
    task automatic test_extremes();
        configure(16'd1920, 16'd1080, 16'd1, 16'd6);
        send_layer(16'hFFFF, 16'hFFFF);
        send_layer(16'hFFFF, 16'd1);
        send_layer(16'd1, 16'hFFFF);
        send_layer(16'd333, 16'd333);
        configure(16'hFFFF, 16'd1, 16'd1, 16'd2);
        send_layer(16'd1, 16'hFFFF);
        send_layer(16'hFFFF, 16'd1);
        configure(16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000);
        send_layer(16'd100, 16'd7);
        configure(16'd1, 16'hFFFF, 16'h7FFF, 16'd1);
        send_layer(16'd7, 16'd100);
    endtask

    // angles on and off the axes, both denominator signs
    task automatic test_angles();
        configure(16'd800, 16'd600, 16'd1, 16'd4);
        send_layer(16'd300, 16'd200);
        configure(16'd800, 16'd600, 16'hFFFF, 16'hFFFE);
        send_layer(16'd300, 16'd200);
        configure(16'd800, 16'd600, 16'd3, 16'hFFFA);
        send_layer(16'd300, 16'd200);
        configure(16'd800, 16'd600, 16'h8000, 16'h7FFF);
        send_layer(16'd300, 16'd200);
    endtask

    // writes to unused indexes leave the registers alone
    task automatic test_unused_index();
        drain();
        for (int i = 4; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), 16'($urandom));
        send_layer(16'd250, 16'd90);
    endtask

    // fixed, then random register settings, each followed by a burst of random sizes
    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
                configure(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000);
            else if (ph == 1)
                configure(16'd1, 16'd1, 16'h8000, 16'hFFFF);
            else
                configure(pick_side(), pick_side(), 16'($urandom), pick_den());
            no_gaps = (ph % 3 == 2);
            for (int k = 0; k < 210; k++)
                send_layer(pick_side(), pick_side());
            no_gaps = 1'b0;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        layer_width  = '0;
        layer_height = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        canvas_w_q   = 16'd1;
        canvas_h_q   = 16'd1;
        rot_num_q    = 16'sd0;
        rot_den_q    = 16'sd1;
        error_count     = 0;
        requests_sent   = 0;
        results_checked = 0;
        no_gaps         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_zero_sizes();
        test_extremes();
        test_angles();
        test_unused_index();
        test_random_phases();

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("sent %0d layer size requests over directed and random register settings",
                 requests_sent);
        $display("checked %0d results, %0d mismatches", results_checked, error_count);
        if (error_count == 0 && pending_fills.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rcfs_pkg.sv
hw/rtl/rcfs_divider.sv
hw/rtl/rcfs_cordic.sv
hw/rtl/rotated_crop_fill_scale_unit.sv
sim/rotated_crop_fill_scale_unit_tb.sv
